// File: rtl/full_linear_convolution_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the full linear convolution block
// Concurrent checks on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef FULL_LINEAR_CONVOLUTION_DEFINES_SVH
`define FULL_LINEAR_CONVOLUTION_DEFINES_SVH

`ifndef ASSERT_OFF

// property must hold on every clock
`define FCL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("full_linear_convolution: assertion failed");

// same-cycle implication
`define FCL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("full_linear_convolution: implication failed");

// next-cycle implication
`define FCL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("full_linear_convolution: next-cycle implication failed");

`else

`define FCL_ASSERT(lbl, prop)
`define FCL_ASSERT_IMP(lbl, ante, cons)
`define FCL_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// File: rtl/fcl_pkg.sv
// ----------------------------------------------------------------------------
// fcl_pkg
// Sizes, codes and shared structs of the full linear convolution block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fcl_pkg;

  // storage depth and sample width
  localparam int MAX_LEN     = 256;
  localparam int SAMPLE_BITS = 16;

  // derived widths
  localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CNT_W  = ADDR_W + 1;          // holds MAX_LEN and k up to 2N-2
  localparam int PROD_W = 2 * SAMPLE_BITS;
  localparam int ACC_W  = 40;
  localparam int IDX_W  = 9;

  // request opcodes
  typedef enum logic {
    OP_PUSH  = 1'b0,
    OP_DRAIN = 1'b1
  } op_e;

  // sequencer to MAC unit
  typedef struct packed {
    logic clr;
    logic vld;
  } mac_ctrl_t;

  // sequencer to output stage
  typedef struct packed {
    logic             load;
    logic             err;
    logic             last;
    logic [IDX_W-1:0] index;
  } res_t;

  // sequence bookkeeping, exported for checks
  typedef struct packed {
    logic [CNT_W-1:0] pair_count;
    logic [CNT_W-1:0] next_index;
    logic             draining;
  } seq_status_t;

endpackage

`default_nettype wire

// File: rtl/fcl_if.sv
// ----------------------------------------------------------------------------
// fcl_in_if / fcl_out_if
// Valid/ready channels carrying requests in and results out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface fcl_in_if
  import fcl_pkg::*;
();
  logic                          valid;
  logic                          ready;
  op_e                           op;
  logic signed [SAMPLE_BITS-1:0] sample_a;
  logic signed [SAMPLE_BITS-1:0] sample_b;
  logic                          end_of_sequence;

  modport source (output valid, op, sample_a, sample_b, end_of_sequence, input ready);
  modport sink   (input valid, op, sample_a, sample_b, end_of_sequence, output ready);
endinterface

interface fcl_out_if
  import fcl_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [ACC_W-1:0] conv_value;
  logic [IDX_W-1:0]        out_index;
  logic                    last;
  logic                    error;

  modport source (output valid, conv_value, out_index, last, error, input ready);
  modport sink   (input valid, conv_value, out_index, last, error, output ready);
endinterface

`default_nettype wire

// File: rtl/fcl_ram.sv
// ----------------------------------------------------------------------------
// fcl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fcl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                          wdata_i,
  input  wire logic                                      re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output      logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/fcl_mac.sv
// ----------------------------------------------------------------------------
// fcl_mac
// Shared multiply-accumulate unit: registered product, then 40-bit sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fcl_mac
  import fcl_pkg::*;
(
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire mac_ctrl_t                     ctrl_i,
  input  wire logic signed [SAMPLE_BITS-1:0] a_i,
  input  wire logic signed [SAMPLE_BITS-1:0] b_i,
  output      logic signed [ACC_W-1:0]       acc_o,
  output      logic                          busy_o
);

  logic signed [PROD_W-1:0] prod_d;
  logic signed [PROD_W-1:0] prod_q;
  logic                     pv_q;
  logic signed [ACC_W-1:0]  acc_q;

  // full-precision signed product
  always_comb begin
    prod_d = PROD_W'(a_i) * PROD_W'(b_i);
  end

  // product stage
  always_ff @(posedge clk_i) begin
    if (ctrl_i.vld) begin
      prod_q <= prod_d;
    end
  end

  // product valid and accumulator; sum wraps modulo 2^40
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q  <= 1'b0;
      acc_q <= '0;
    end else begin
      pv_q <= ctrl_i.vld;
      if (ctrl_i.clr) begin
        acc_q <= '0;
      end else if (pv_q) begin
        acc_q <= acc_q + ACC_W'(prod_q);
      end
    end
  end

  assign acc_o  = acc_q;
  assign busy_o = pv_q;

endmodule

`default_nettype wire

// File: rtl/fcl_seq.sv
// ----------------------------------------------------------------------------
// fcl_seq
// Sequencer: sequence bookkeeping, store writes and the MAC index walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fcl_seq
  import fcl_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire op_e               op_i,
  input  wire logic              end_of_sequence_i,
  input  wire logic              mac_busy_i,
  input  wire logic              slot_free_i,
  output      logic              in_ready_o,
  output      logic              we_o,
  output      logic [ADDR_W-1:0] waddr_o,
  output      logic              re_o,
  output      logic [ADDR_W-1:0] raddr_a_o,
  output      logic [ADDR_W-1:0] raddr_b_o,
  output      mac_ctrl_t         mac_ctrl_o,
  output      res_t              res_o,
  output      seq_status_t       status_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] pair_cnt_q;
  logic [CNT_W-1:0] next_idx_q;
  logic             drain_q;
  logic [CNT_W-1:0] k_q;
  logic [CNT_W-1:0] i_q;
  logic [CNT_W-1:0] hi_q;
  logic             iss_q;
  logic             err_q;
  logic             last_q;

  logic             accept;
  logic             push_err;
  logic             drain_last;
  logic [CNT_W-1:0] j;
  logic             finish;

  // request decode and index walk
  always_comb begin
    accept     = in_valid_i && (state_q == S_IDLE);
    push_err   = drain_q || (pair_cnt_q >= CNT_W'(MAX_LEN));
    drain_last = ({1'b0, next_idx_q} + (CNT_W + 1)'(2)) >= {pair_cnt_q, 1'b0};
    j          = k_q - i_q;
    finish     = (state_q == S_DONE) && !iss_q && !mac_busy_i && slot_free_i;
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign we_o       = accept && (op_i == OP_PUSH) && !push_err;
  assign waddr_o    = pair_cnt_q[ADDR_W-1:0];
  assign re_o       = (state_q == S_RUN);
  assign raddr_a_o  = i_q[ADDR_W-1:0];
  assign raddr_b_o  = j[ADDR_W-1:0];

  assign mac_ctrl_o.clr = accept;
  assign mac_ctrl_o.vld = iss_q;

  assign res_o.load  = finish;
  assign res_o.err   = err_q;
  assign res_o.last  = last_q;
  assign res_o.index = IDX_W'(k_q);

  assign status_o.pair_count = pair_cnt_q;
  assign status_o.next_index = next_idx_q;
  assign status_o.draining   = drain_q;

  // state, bookkeeping and walk counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      pair_cnt_q <= '0;
      next_idx_q <= '0;
      drain_q    <= 1'b0;
      k_q        <= '0;
      i_q        <= '0;
      hi_q       <= '0;
      iss_q      <= 1'b0;
      err_q      <= 1'b0;
      last_q     <= 1'b0;
    end else begin
      iss_q <= re_o;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            err_q   <= 1'b0;
            last_q  <= 1'b0;
            state_q <= S_RUN;
            if (op_i == OP_PUSH) begin
              if (push_err) begin
                err_q   <= 1'b1;
                k_q     <= '0;
                state_q <= S_DONE;
              end else begin
                // output k spans stored elements 0..k
                k_q  <= pair_cnt_q;
                i_q  <= '0;
                hi_q <= pair_cnt_q;
                if (end_of_sequence_i && (pair_cnt_q == '0)) begin
                  // single-element sequence closes at once
                  last_q <= 1'b1;
                end else if (end_of_sequence_i) begin
                  pair_cnt_q <= pair_cnt_q + 1'b1;
                  next_idx_q <= pair_cnt_q + 1'b1;
                  drain_q    <= 1'b1;
                end else begin
                  pair_cnt_q <= pair_cnt_q + 1'b1;
                end
              end
            end else begin
              if (!drain_q) begin
                err_q   <= 1'b1;
                k_q     <= '0;
                state_q <= S_DONE;
              end else begin
                // tail output k spans i = k+1-N .. N-1
                k_q  <= next_idx_q;
                i_q  <= next_idx_q + 1'b1 - pair_cnt_q;
                hi_q <= pair_cnt_q - 1'b1;
                if (drain_last) begin
                  last_q     <= 1'b1;
                  pair_cnt_q <= '0;
                  next_idx_q <= '0;
                  drain_q    <= 1'b0;
                end else begin
                  next_idx_q <= next_idx_q + 1'b1;
                end
              end
            end
          end
        end
        S_RUN: begin
          i_q <= i_q + 1'b1;
          if (i_q == hi_q) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (finish) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/full_linear_convolution.sv
// ----------------------------------------------------------------------------
// full_linear_convolution
// Streaming full linear convolution of two sample sequences on one MAC.
// ----------------------------------------------------------------------------
//  port    dir  carries
//  in_i    in   op, sample_a, sample_b, end_of_sequence
//  out_o   out  conv_value, out_index, last, error
//
//  Output k walks its product terms through store read, product register
//  and accumulator, then goes to the result register; an error request
//  skips the walk. A new request is taken only after the result is loaded.
//  Throughput is set by the single multiply-accumulate unit.
//  Reset clears the sequence state; the sample stores need no clearing.
//  The result register frees the input side; a stalled result holds back
//  only the next completion.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "full_linear_convolution_defines.svh"

module full_linear_convolution
  import fcl_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  fcl_in_if.sink     in_i,
  fcl_out_if.source  out_o
);

  logic                          we;
  logic [ADDR_W-1:0]             waddr;
  logic                          re;
  logic [ADDR_W-1:0]             raddr_a;
  logic [ADDR_W-1:0]             raddr_b;
  logic signed [SAMPLE_BITS-1:0] rd_a;
  logic signed [SAMPLE_BITS-1:0] rd_b;
  mac_ctrl_t                     mac_ctrl;
  logic signed [ACC_W-1:0]       acc;
  logic                          mac_busy;
  res_t                          res;
  seq_status_t                   st;
  logic                          slot_free;
  logic                          in_ready;

  logic                          out_valid_q;
  logic signed [ACC_W-1:0]       out_value_q;
  logic [IDX_W-1:0]              out_index_q;
  logic                          out_last_q;
  logic                          out_err_q;

  fcl_seq u_seq (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_i.valid),
    .op_i              (in_i.op),
    .end_of_sequence_i (in_i.end_of_sequence),
    .mac_busy_i        (mac_busy),
    .slot_free_i       (slot_free),
    .in_ready_o        (in_ready),
    .we_o              (we),
    .waddr_o           (waddr),
    .re_o              (re),
    .raddr_a_o         (raddr_a),
    .raddr_b_o         (raddr_b),
    .mac_ctrl_o        (mac_ctrl),
    .res_o             (res),
    .status_o          (st)
  );

  // first sequence store
  fcl_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_LEN)
  ) u_store_a (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (in_i.sample_a),
    .re_i    (re),
    .raddr_i (raddr_a),
    .rdata_o (rd_a)
  );

  // second sequence store
  fcl_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_LEN)
  ) u_store_b (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (in_i.sample_b),
    .re_i    (re),
    .raddr_i (raddr_b),
    .rdata_o (rd_b)
  );

  fcl_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .a_i    (rd_a),
    .b_i    (rd_b),
    .acc_o  (acc),
    .busy_o (mac_busy)
  );

  assign in_i.ready = in_ready;
  assign slot_free  = !out_valid_q || out_o.ready;

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.load) begin
      out_value_q <= res.err ? '0 : acc;
      out_index_q <= res.index;
      out_last_q  <= res.last;
      out_err_q   <= res.err;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.conv_value = out_value_q;
  assign out_o.out_index  = out_index_q;
  assign out_o.last       = out_last_q;
  assign out_o.error      = out_err_q;

  // checks
  `FCL_ASSERT(a_count_cap, st.pair_count <= CNT_W'(MAX_LEN))
  `FCL_ASSERT_IMP(a_drain_span, st.draining,
                  (st.next_index >= st.pair_count) && (st.pair_count >= CNT_W'(2)))
  `FCL_ASSERT_IMP(a_err_result, out_valid_q && out_err_q, (out_value_q == '0) && !out_last_q)
  `FCL_ASSERT_NXT(a_busy_after_request, in_i.valid && in_i.ready, !in_i.ready)

endmodule

`default_nettype wire
